// ----- hdl/srtf_preemptive_scheduler_top_macros.svh -----
// Assertion macros used by the scheduler's datapath RTL file (srtf_dp).
// Each macro checks one implication under the synchronous reset.
`ifndef SRTF_PREEMPTIVE_SCHEDULER_TOP_MACROS_SVH
`define SRTF_PREEMPTIVE_SCHEDULER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SRTF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srtf assertion failed");
// Next-cycle implication.
`define SRTF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srtf assertion failed");
`else
`define SRTF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SRTF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/srtf_pkg.sv -----
package srtf_pkg;

  // Fixed field widths of the item formats.
  localparam int unsigned TBL_W  = 16;
  localparam int unsigned SLOT_W = 4;

  // Operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [TBL_W-1:0]  arrival_time;
    logic [TBL_W-1:0]  burst_time;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_id;
    logic              load_accepted;
    logic              idle_tick;
    logic              finished;
    logic [TBL_W-1:0]  completion_time;
    logic [TBL_W-1:0]  turnaround_time;
    logic              all_done;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_go;
    logic tick_go;
    logic rd_go;
    logic upd_go;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic all_read;
  } ctrl_sts_t;

endpackage

// ----- hdl/srtf_ram.sv -----
module srtf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/srtf_ctrl.sv -----
module srtf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                operation,
  input  srtf_pkg::ctrl_sts_t sts,
  output srtf_pkg::ctrl_cmd_t cmd,
  output logic                busy
);

  import srtf_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = start && (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (operation == OP_TICK)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.all_read) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.load_go = accept && (operation == OP_LOAD);
        cmd.tick_go = accept && (operation == OP_TICK);
      end
      S_SCAN: begin
        cmd.rd_go = !sts.all_read;
      end
      S_UPDATE: begin
        cmd.upd_go = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ----- hdl/srtf_dp.sv -----
`include "srtf_preemptive_scheduler_top_macros.svh"
module srtf_dp #(
  parameter int unsigned MAX_PROCS = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  srtf_pkg::in_item_t  in_item,
  input  srtf_pkg::ctrl_cmd_t cmd,
  output srtf_pkg::ctrl_sts_t sts,
  output srtf_pkg::out_item_t out_item,
  output logic                out_valid
);

  import srtf_pkg::*;

  localparam int unsigned SW  = $clog2(MAX_PROCS);
  localparam int unsigned LCW = $clog2(MAX_PROCS + 1);
  localparam int unsigned CW  = (TIME_BITS > TBL_W) ? TIME_BITS : TBL_W;
  localparam int unsigned RW  = 2 * TBL_W;

  logic [TIME_BITS-1:0] time_r;
  logic [TIME_BITS-1:0] time_nxt;
  logic [LCW-1:0]       loaded_r;
  logic [LCW-1:0]       finished_r;
  logic [LCW-1:0]       cnt_r;
  logic                 cmp_vld_r;
  logic                 found_r;
  logic [SW-1:0]        best_slot_r;
  logic [TBL_W-1:0]     best_rem_r;
  logic [TBL_W-1:0]     best_arr_r;
  logic                 out_valid_r;
  out_item_t            out_r;
  out_item_t            out_nxt;

  logic                 we;
  logic [SW-1:0]        waddr;
  logic [RW-1:0]        wdata;
  logic [RW-1:0]        rdata;
  logic [TBL_W-1:0]     rd_arr;
  logic [TBL_W-1:0]     rd_rem;
  logic                 elig;
  logic                 take;
  logic                 load_ok;
  logic [TBL_W-1:0]     rem_dec;
  logic                 fin_now;
  logic [CW-1:0]        time_after_x;
  logic [CW-1:0]        tat_x;
  logic [SW+SLOT_W-1:0] load_slot_ext;
  logic [SW+SLOT_W-1:0] best_slot_ext;
  logic [LCW-1:0]       loaded_inc;
  logic [LCW-1:0]       finished_inc;

  srtf_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_PROCS)
  ) u_tbl (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_go),
    .raddr (cnt_r[SW-1:0]),
    .rdata (rdata)
  );

  assign rd_arr = rdata[RW-1:TBL_W];
  assign rd_rem = rdata[TBL_W-1:0];

  // A slot competes when it has arrived by the current time and has work left.
  assign elig = (CW'(rd_arr) <= CW'(time_r)) && (rd_rem != '0);
  assign take = cmp_vld_r && elig && (!found_r || (rd_rem < best_rem_r));

  assign load_ok      = (loaded_r < LCW'(MAX_PROCS)) && (in_item.burst_time != '0);
  assign rem_dec      = best_rem_r - TBL_W'(1);
  assign fin_now      = found_r && (rem_dec == '0);
  assign time_nxt     = (time_r != {TIME_BITS{1'b1}}) ? time_r + TIME_BITS'(1) : time_r;
  assign time_after_x = CW'(time_nxt);
  assign tat_x        = time_after_x - CW'(best_arr_r);
  assign loaded_inc   = loaded_r + LCW'(1);
  assign finished_inc = finished_r + LCW'(1);
  assign load_slot_ext = {{SLOT_W{1'b0}}, loaded_r[SW-1:0]};
  assign best_slot_ext = {{SLOT_W{1'b0}}, best_slot_r};

  always_comb begin
    we    = 1'b0;
    waddr = best_slot_r;
    wdata = {best_arr_r, rem_dec};
    if (cmd.load_go && load_ok) begin
      we    = 1'b1;
      waddr = loaded_r[SW-1:0];
      wdata = {in_item.arrival_time, in_item.burst_time};
    end else if (cmd.upd_go && found_r) begin
      we = 1'b1;
    end
  end

  assign sts.all_read = (cnt_r == loaded_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= '0;
      loaded_r    <= '0;
      finished_r  <= '0;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.load_go || cmd.upd_go;
      cmp_vld_r   <= cmd.rd_go;
      if (cmd.tick_go) begin
        cnt_r   <= '0;
        found_r <= 1'b0;
      end
      if (cmd.rd_go) begin
        cnt_r <= cnt_r + LCW'(1);
      end
      if (take) begin
        found_r <= 1'b1;
      end
      if (cmd.load_go && load_ok) begin
        loaded_r <= loaded_inc;
      end
      if (cmd.upd_go) begin
        time_r <= time_nxt;
        if (fin_now) begin
          finished_r <= finished_inc;
        end
      end
    end
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd.load_go) begin
      out_nxt               = '0;
      out_nxt.load_accepted = load_ok;
      out_nxt.slot_id       = load_ok ? load_slot_ext[SLOT_W-1:0] : '0;
      out_nxt.all_done      = load_ok ? (finished_r == loaded_inc) : (finished_r == loaded_r);
    end else if (cmd.upd_go) begin
      out_nxt           = '0;
      out_nxt.idle_tick = !found_r;
      out_nxt.slot_id   = found_r ? best_slot_ext[SLOT_W-1:0] : '0;
      out_nxt.finished  = fin_now;
      if (fin_now) begin
        out_nxt.completion_time = time_after_x[TBL_W-1:0];
        out_nxt.turnaround_time = tat_x[TBL_W-1:0];
        out_nxt.all_done        = (finished_inc == loaded_r);
      end else begin
        out_nxt.all_done        = (finished_r == loaded_r);
      end
    end
  end

  // Best candidate and result payload carry no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      best_slot_r <= cnt_r[SW-1:0] - SW'(1);
      best_rem_r  <= rd_rem;
      best_arr_r  <= rd_arr;
    end
    out_r <= out_nxt;
  end

  assign out_item  = out_r;
  assign out_valid = out_valid_r;

  `SRTF_ASSERT_IMP(a_fin_le_loaded, clk, rst_n, 1'b1, finished_r <= loaded_r)
  `SRTF_ASSERT_IMP(a_cnt_le_loaded, clk, rst_n, 1'b1, cnt_r <= loaded_r)
  `SRTF_ASSERT_NXT(a_upd_strobe, clk, rst_n, cmd.upd_go, out_valid_r && !out_r.load_accepted)
  `SRTF_ASSERT_IMP(a_load_clean, clk, rst_n, out_valid_r && out_r.load_accepted, !out_r.finished)

endmodule

// ----- hdl/srtf_preemptive_scheduler_top.sv -----
// Load item: accepted while idle, one load per cycle; its result strobes in the next cycle.
// Tick item: holds busy high through the scan of all loaded slots and the update step,
//   and no new item is accepted until busy falls; the result strobes in the first cycle
//   after busy falls. One table slot is read and compared per cycle through one read port.
// The receiver cannot stall results; a load may be accepted while a tick's result strobes.
// Synchronous active-low reset clears time, counts and control; table contents stay.
module srtf_preemptive_scheduler_top #(
  parameter int unsigned MAX_PROCS = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  srtf_pkg::in_item_t in_item,
  output srtf_pkg::out_item_t out_item,
  output logic               out_valid
);

  import srtf_pkg::*;

  // The controller sequences loads and the per-tick table scan; the datapath
  // owns the process table, the time counter and the running-minimum search.
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  srtf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_item.operation),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  // During a scan the datapath walks every loaded slot in order, keeping the
  // eligible slot with the least remaining time; a strict compare keeps the lowest
  // slot on ties. The update step then decrements that slot's remaining time
  // in place, advances time with saturation and forms the result item.
  srtf_dp #(
    .MAX_PROCS (MAX_PROCS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item),
    .out_valid (out_valid)
  );

endmodule
